[rtl/core/urde_pkg.sv]
package urde_pkg;

	// Request codes
	typedef enum logic [1:0] {
		REQ_READ    = 2'd0,
		REQ_WRITE   = 2'd1,
		REQ_RX_BYTE = 2'd2,
		REQ_TIMEOUT = 2'd3
	} req_type_t;

	// Completion status codes
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_TIMEOUT = 2'd1,
		ST_CRC_ERR = 2'd2
	} status_t;

	localparam logic [7:0] SYNC_BYTE      = 8'h05;
	localparam logic [7:0] CRC_POLY       = 8'h07;
	localparam logic [7:0] WRITE_FLAG     = 8'h80;
	localparam logic [3:0] READ_RX_TOTAL  = 4'd12;
	localparam logic [3:0] WRITE_RX_TOTAL = 4'd8;
	localparam logic [3:0] DGRAM_BYTES    = 4'd8;
	localparam logic [2:0] READ_LAST_IDX  = 3'd3;
	localparam logic [2:0] WRITE_LAST_IDX = 3'd7;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [7:0]  node_addr;
		logic [6:0]  reg_addr;
		logic [31:0] write_data;
		logic [7:0]  rx_byte;
	} req_t;

	typedef struct packed {
		logic        tx_valid;
		logic [7:0]  tx_byte;
		logic        last;
		logic        done_res;
		logic [1:0]  reply_status;
		logic [31:0] read_data;
	} res_t;

	// Advance a CRC-8 by one byte, data taken least significant bit first
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		logic       fb;
		c = crc;
		for (int j = 0; j < 8; j++) begin
			fb = c[7] ^ data[j];
			c = {c[6:0], 1'b0};
			if (fb) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

endpackage

[rtl/core/uart_register_datagram_engine_core.sv]
// Frames single-wire register accesses: a read request emits a 4-byte datagram
// and a write request an 8-byte one (sync, node, register with write flag in
// bit 7, data most significant first on writes, CRC-8 poly 0x07 over bytes
// taken LSB first), one result per byte. Received bytes are counted against
// the expected echo and reply, the final 8-byte datagram is CRC-checked, and a
// single completion result carries the status and read data; a timeout while
// busy completes with status timed out. A request aborts any pending one, and
// bytes or timeouts while idle are dropped. The block holds one result lane:
// a read request fills it with 4 results, a write with 8, a completion with 1,
// and an item that causes no result adds none; the next item is accepted
// in the same cycle that the last result of the previous one is taken. Both
// CRCs are built one byte per cycle unless stalled, the transmit CRC as bytes
// leave and the receive CRC as bytes arrive. Reset is immediate; no clearing pass.
module uart_register_datagram_engine_core
	import urde_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);

	// Transaction state
	logic        busy_q;
	logic        is_read_q;
	logic [3:0]  rx_count_q;
	logic [63:0] rx_frame_q;
	logic [7:0]  rx_crc_q;

	// Result lane
	logic        res_valid_q;
	logic [7:0]  frame_q [7];
	logic [2:0]  idx_q;
	logic [2:0]  last_idx_q;
	logic        done_q;
	status_t     status_q;
	logic [31:0] rdata_q;
	logic [7:0]  tx_crc_q;

	req_type_t   rtype;
	logic        req_fire;
	logic        res_fire;
	logic        res_last;
	logic        res_load;
	logic [3:0]  rx_total;
	logic [3:0]  rx_count_nx;
	logic [63:0] rx_frame_nx;
	logic [7:0]  rx_crc_nx;
	logic [7:0]  cur_byte;

	assign rtype    = req_type_t'(req.req_type);
	assign res_last = (idx_q == last_idx_q);
	assign res_fire = res_valid_q && !res_stall;

	// Hold off new transactions while the lane holds results, except when its last is taken
	assign req_stall = res_valid_q && !(res_last && !res_stall);
	assign req_fire  = req_valid && !req_stall;

	// Receive path: shift in the byte and advance the windowed CRC
	assign rx_total    = is_read_q ? READ_RX_TOTAL : WRITE_RX_TOTAL;
	assign rx_count_nx = rx_count_q + 4'd1;
	assign rx_frame_nx = {req.rx_byte, rx_frame_q[63:8]};
	assign rx_crc_nx   = (rx_count_nx > (rx_total - DGRAM_BYTES)) ?
	                     crc8_byte(rx_crc_q, req.rx_byte) : 8'h00;

	// Flag a transaction that refills the lane
	assign res_load = req_fire && ((rtype == REQ_READ) || (rtype == REQ_WRITE) ||
	                  (busy_q && (rtype == REQ_TIMEOUT)) ||
	                  (busy_q && (rtype == REQ_RX_BYTE) && (rx_count_nx == rx_total)));

	// Select the byte in flight
	assign cur_byte = res_last ? tx_crc_q : frame_q[idx_q];

	always_comb begin
		res_valid        = res_valid_q;
		res.tx_valid     = !done_q;
		res.tx_byte      = done_q ? 8'h00 : cur_byte;
		res.last         = res_last;
		res.done_res     = done_q;
		res.reply_status = done_q ? status_q : ST_OK;
		res.read_data    = done_q ? rdata_q : 32'h0;
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			is_read_q   <= 1'b0;
			rx_count_q  <= 4'd0;
			rx_frame_q  <= 64'h0;
			rx_crc_q    <= 8'h00;
			res_valid_q <= 1'b0;
			idx_q       <= 3'd0;
			last_idx_q  <= 3'd0;
			done_q      <= 1'b0;
			status_q    <= ST_OK;
			tx_crc_q    <= 8'h00;
		end else begin
			// Drain the lane one result per handshake; empty it unless refilled
			if (res_fire) begin
				if (res_last) begin
					if (!res_load) begin
						res_valid_q <= 1'b0;
					end
				end else begin
					idx_q    <= idx_q + 3'd1;
					tx_crc_q <= crc8_byte(tx_crc_q, frame_q[idx_q]);
				end
			end
			if (req_fire) begin
				unique case (rtype)
					REQ_READ, REQ_WRITE: begin
						busy_q      <= 1'b1;
						is_read_q   <= (rtype == REQ_READ);
						rx_count_q  <= 4'd0;
						rx_frame_q  <= 64'h0;
						rx_crc_q    <= 8'h00;
						res_valid_q <= 1'b1;
						idx_q       <= 3'd0;
						last_idx_q  <= (rtype == REQ_WRITE) ? WRITE_LAST_IDX : READ_LAST_IDX;
						done_q      <= 1'b0;
						status_q    <= ST_OK;
						tx_crc_q    <= 8'h00;
					end
					REQ_TIMEOUT: begin
						if (busy_q) begin
							busy_q      <= 1'b0;
							rx_count_q  <= 4'd0;
							res_valid_q <= 1'b1;
							idx_q       <= 3'd0;
							last_idx_q  <= 3'd0;
							done_q      <= 1'b1;
							status_q    <= ST_TIMEOUT;
						end
					end
					REQ_RX_BYTE: begin
						if (busy_q) begin
							rx_frame_q <= rx_frame_nx;
							rx_crc_q   <= rx_crc_nx;
							if (rx_count_nx == rx_total) begin
								busy_q      <= 1'b0;
								rx_count_q  <= 4'd0;
								res_valid_q <= 1'b1;
								idx_q       <= 3'd0;
								last_idx_q  <= 3'd0;
								done_q      <= 1'b1;
								status_q    <= (rx_crc_q == req.rx_byte) ? ST_OK : ST_CRC_ERR;
							end else begin
								rx_count_q <= rx_count_nx;
							end
						end
					end
				endcase
			end
		end
	end

	// Payload of the lane
	always_ff @(posedge clk) begin
		if (req_fire) begin
			unique case (rtype)
				REQ_READ, REQ_WRITE: begin
					frame_q[0] <= SYNC_BYTE;
					frame_q[1] <= req.node_addr;
					frame_q[2] <= {1'b0, req.reg_addr} | ((rtype == REQ_WRITE) ? WRITE_FLAG : 8'h00);
					frame_q[3] <= req.write_data[31:24];
					frame_q[4] <= req.write_data[23:16];
					frame_q[5] <= req.write_data[15:8];
					frame_q[6] <= req.write_data[7:0];
				end
				REQ_TIMEOUT: begin
					rdata_q <= 32'h0;
				end
				REQ_RX_BYTE: begin
					rdata_q <= {rx_frame_nx[31:24], rx_frame_nx[39:32],
					            rx_frame_nx[47:40], rx_frame_nx[55:48]};
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	// Stall only while a result is waiting
	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> res_valid)
		else $error("stall without a pending result");

	// A completion is always a single, final result
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.done_res) |-> (res.last && !res.tx_valid))
		else $error("completion result not marked last");

	// A request starts its frame with the sync byte
	a_frame_starts_sync: assert property (@(posedge clk) disable iff (!arst_n)
		(req_fire && (rtype == REQ_READ || rtype == REQ_WRITE)) |=>
		(res_valid && res.tx_valid && res.tx_byte == SYNC_BYTE))
		else $error("frame does not open with sync byte");

	// Receive count stays below the expected total and clears when idle
	a_rx_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(rx_count_q < rx_total) && (busy_q || rx_count_q == 4'd0))
		else $error("receive count out of range");
`endif

endmodule
